FILE: hw/rtl/swm_pkg.sv
// Shared types and constants for the sliding window median block.
// No dependencies; every other file of the block refers to it by scoped names.
package swm_pkg;

   localparam int SAMPLE_W       = 32;
   localparam int COUNT_W        = 4;
   localparam int COUNT_MAX      = 15;
   localparam int WINDOW_LEN_DEF = 8;

   // What a cell shows its neighbors: stored value and whether it sorts above the request
   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                gt;
   } link_type;

endpackage

FILE: hw/rtl/sliding_window_median.sv
// An accepted request updates the cell chain; the result stage then registers its median.
// Throughput: one request per cycle while the response side is not stalled; the sorted
// cell chain removes the oldest entry and inserts the new sample in the same cycle.
// Reset (synchronous) empties the window to zeros and clears all handshake state at once.
// Depends on swm_pkg, swm_cell and swm_out.
module sliding_window_median #(
   parameter int WINDOW_LEN = swm_pkg::WINDOW_LEN_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [swm_pkg::SAMPLE_W-1:0] req_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [swm_pkg::SAMPLE_W-1:0] rsp_median,
   output logic [swm_pkg::COUNT_W-1:0]  rsp_valid_count
);

   localparam int AGE_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int CNT_W = $clog2(WINDOW_LEN + 1);

   swm_pkg::link_type            links [WINDOW_LEN];
   logic [AGE_W-1:0]             ages [WINDOW_LEN];
   logic [swm_pkg::SAMPLE_W-1:0] values [WINDOW_LEN];
   logic [WINDOW_LEN:0]          evict_chain;
   logic [WINDOW_LEN-1:0]        evict_nz;
   logic                         accept;
   logic                         out_load;
   logic                         pend_ff, pend_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]             count_ff, count_in;

   // Stall in reset, or while an updated window waits behind a blocked response
   assign req_stall = reset | (pend_ff & rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;
   assign out_load  = pend_ff & (~rsp_valid_ff | ~rsp_stall);

   assign evict_chain[0] = 1'b0;

   // Build the sorted chain of cells
   for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
      swm_pkg::link_type left_link, right_link;
      logic [AGE_W-1:0]  left_age, right_age;

      if (i == 0) begin : g_first
         assign left_link = '{value: '0, gt: 1'b0};
         assign left_age  = '0;
      end else begin : g_inner_l
         assign left_link = links[i-1];
         assign left_age  = ages[i-1];
      end
      if (i == WINDOW_LEN - 1) begin : g_last
         assign right_link = '{value: '0, gt: 1'b1};
         assign right_age  = '0;
      end else begin : g_inner_r
         assign right_link = links[i+1];
         assign right_age  = ages[i+1];
      end

      swm_cell #(
         .WINDOW_LEN(WINDOW_LEN),
         .AGE_W     (AGE_W),
         .INDEX     (i)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .load            (accept),
         .new_value       (req_sample),
         .left_link       (left_link),
         .left_age        (left_age),
         .right_link      (right_link),
         .right_age       (right_age),
         .evict_before_in (evict_chain[i]),
         .own_link        (links[i]),
         .own_age         (ages[i]),
         .evict_before_out(evict_chain[i+1]),
         .evict_nz        (evict_nz[i])
      );

      assign values[i] = links[i].value;
   end

   // Track the nonzero count and the response handshake
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = count_ff + CNT_W'(req_sample != '0) - CNT_W'(evict_nz != '0);
      end
      pend_in      = accept | (pend_ff & ~out_load);
      rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   swm_out #(
      .WINDOW_LEN(WINDOW_LEN),
      .AGE_W     (AGE_W),
      .CNT_W     (CNT_W)
   ) u_out (
      .clock      (clock),
      .load       (out_load),
      .values     (values),
      .count      (count_ff),
      .median     (rsp_median),
      .valid_count(rsp_valid_count)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hw/rtl/swm_cell.sv
// One cell of the sorted window chain: holds a value and its age.
// Depends on swm_pkg; instantiated in a row by sliding_window_median.
module swm_cell #(
   parameter int WINDOW_LEN = swm_pkg::WINDOW_LEN_DEF,
   parameter int AGE_W      = 3,
   parameter int INDEX      = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic [swm_pkg::SAMPLE_W-1:0] new_value,
   input  swm_pkg::link_type            left_link,
   input  logic [AGE_W-1:0]             left_age,
   input  swm_pkg::link_type            right_link,
   input  logic [AGE_W-1:0]             right_age,
   input  logic                         evict_before_in,
   output swm_pkg::link_type            own_link,
   output logic [AGE_W-1:0]             own_age,
   output logic                         evict_before_out,
   output logic                         evict_nz
);

   logic [swm_pkg::SAMPLE_W-1:0] value_ff, value_in;
   logic [AGE_W-1:0]             age_ff, age_in;
   logic                         evict_self;
   logic                         self_gt;
   swm_pkg::link_type            c_self_link, c_left_link;
   logic [AGE_W-1:0]             c_self_age, c_left_age;

   assign self_gt          = value_ff > new_value;
   assign evict_self       = age_ff == AGE_W'(WINDOW_LEN - 1);
   assign own_link.value   = value_ff;
   assign own_link.gt      = self_gt;
   assign own_age          = age_ff;
   assign evict_before_out = evict_before_in | evict_self;
   assign evict_nz         = evict_self & (value_ff != '0);

   // Remove the oldest entry, then insert the request at its sorted place
   always_comb begin
      if (evict_before_in || evict_self) begin
         c_self_link = right_link;
         c_self_age  = right_age;
      end else begin
         c_self_link.value = value_ff;
         c_self_link.gt    = self_gt;
         c_self_age        = age_ff;
      end
      if (evict_before_in) begin
         c_left_link.value = value_ff;
         c_left_link.gt    = self_gt;
         c_left_age        = age_ff;
      end else begin
         c_left_link = left_link;
         c_left_age  = left_age;
      end
      if (c_left_link.gt) begin
         value_in = c_left_link.value;
         age_in   = c_left_age + AGE_W'(1);
      end else if (c_self_link.gt) begin
         value_in = new_value;
         age_in   = '0;
      end else begin
         value_in = c_self_link.value;
         age_in   = c_self_age + AGE_W'(1);
      end
   end

   // Advance on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         age_ff   <= AGE_W'(INDEX);
      end else if (load) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

endmodule

FILE: hw/rtl/swm_out.sv
// Result stage: picks the median cell from the sorted chain and saturates the count.
// Depends on swm_pkg; instantiated by sliding_window_median.
module swm_out #(
   parameter int WINDOW_LEN = swm_pkg::WINDOW_LEN_DEF,
   parameter int AGE_W      = 3,
   parameter int CNT_W      = 4
) (
   input  logic                         clock,
   input  logic                         load,
   input  logic [swm_pkg::SAMPLE_W-1:0] values [WINDOW_LEN],
   input  logic [CNT_W-1:0]             count,
   output logic [swm_pkg::SAMPLE_W-1:0] median,
   output logic [swm_pkg::COUNT_W-1:0]  valid_count
);

   localparam int EXT_W = CNT_W + swm_pkg::COUNT_W;

   logic [swm_pkg::SAMPLE_W-1:0] median_ff, median_in;
   logic [swm_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [CNT_W:0]               half_up;
   logic [CNT_W:0]               idx_full;
   logic [AGE_W-1:0]             idx;
   logic [EXT_W-1:0]             count_ext;

   // Zeros sort first, so the upper median sits at cell index WINDOW_LEN - ceil(n/2)
   always_comb begin
      half_up   = ((CNT_W + 1)'(count) + (CNT_W + 1)'(1)) >> 1;
      idx_full  = (CNT_W + 1)'(WINDOW_LEN) - half_up;
      idx       = idx_full[AGE_W-1:0];
      median_in = (count == '0) ? '0 : values[idx];
      count_ext = EXT_W'(count);
      if (count_ext > EXT_W'(swm_pkg::COUNT_MAX)) begin
         count_in = swm_pkg::COUNT_W'(swm_pkg::COUNT_MAX);
      end else begin
         count_in = count_ext[swm_pkg::COUNT_W-1:0];
      end
   end

   // Hold the result until the next load
   always_ff @(posedge clock) begin
      if (load) begin
         median_ff <= median_in;
         count_ff  <= count_in;
      end
   end

   assign median      = median_ff;
   assign valid_count = count_ff;

endmodule

FILE: hw/rtl/swm_check.sv
// Port-level checks for sliding_window_median, attached to it by the bind below.
// Depends on swm_pkg and on the top level's ports.
module swm_check #(
   parameter int WINDOW_LEN = swm_pkg::WINDOW_LEN_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [swm_pkg::SAMPLE_W-1:0] rsp_median,
   input logic [swm_pkg::COUNT_W-1:0]  rsp_valid_count
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_median)
                                 && $stable(rsp_valid_count))
      else $error("stalled response changed");

   // A valid response follows every accepted request
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##2 rsp_valid)
      else $error("response missing after accepted request");

   // Back-pressure reaches the request side only through a blocked response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without response back-pressure");

   // A zero median means an empty window and nothing else
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_valid_count == '0) == (rsp_median == '0)))
      else $error("median and count disagree on an empty window");

   // Count never exceeds the window length
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_valid_count) <= 32'(WINDOW_LEN)))
      else $error("valid count above window length");

endmodule

bind sliding_window_median swm_check #(.WINDOW_LEN(WINDOW_LEN)) u_swm_check (.*);
